@@ hw/rtl/glyph_alpha_blend_blit_core_defines.svh @@
// Assertion macros for the glyph blit core checker.
// Used by gabb_checker.sv; expects clk and rst_n in the including scope.
`ifndef GLYPH_ALPHA_BLEND_BLIT_CORE_DEFINES_SVH
`define GLYPH_ALPHA_BLEND_BLIT_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define GABB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define GABB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/gabb_pkg.sv @@
// Shared types and constants for the glyph alpha-blend blit core.
// No dependencies; compile first.
`timescale 1ns / 1ps

package gabb_pkg;

    localparam int GABB_MAX_GLYPH_WIDTH = 256;
    localparam int ROW_W       = 12;
    localparam int COORD_W     = 14;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_WIDTH = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FG_COLOR    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CLIP_LEFT   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_CLIP_TOP    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_CLIP_RIGHT  = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_CLIP_BOTTOM = 3'd7;

    typedef struct packed {
        logic signed [12:0] origin_x;
        logic signed [12:0] origin_y;
        logic [8:0]         glyph_width;
        logic [23:0]        fg_color;
        logic [12:0]        clip_left;
        logic [12:0]        clip_top;
        logic [12:0]        clip_right;
        logic [12:0]        clip_bottom;
    } cfg_t;

    // one bitmap word after position lookup
    typedef struct packed {
        logic [7:0]                coverage;
        logic [7:0]                bg_red;
        logic [7:0]                bg_green;
        logic [7:0]                bg_blue;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
    } stage_t;

endpackage

@@ hw/rtl/gabb_ifs.sv @@
// Stream interfaces for the glyph blit core: bitmap words in, pixel words out.
// No dependencies.
`timescale 1ns / 1ps

interface gabb_bitmap_if;
    logic       valid;
    logic       ready;
    logic [7:0] coverage;
    logic [7:0] bg_red;
    logic [7:0] bg_green;
    logic [7:0] bg_blue;
    logic       glyph_last;

    modport source (output valid, coverage, bg_red, bg_green, bg_blue, glyph_last,
                    input ready);
    modport sink   (input valid, coverage, bg_red, bg_green, bg_blue, glyph_last,
                    output ready);
endinterface

interface gabb_pixel_if;
    logic              valid;
    logic              ready;
    logic              write_pixel;
    logic signed [13:0] pos_x;
    logic signed [13:0] pos_y;
    logic [7:0]        out_red;
    logic [7:0]        out_green;
    logic [7:0]        out_blue;

    modport source (output valid, write_pixel, pos_x, pos_y, out_red, out_green,
                    out_blue, input ready);
    modport sink   (input valid, write_pixel, pos_x, pos_y, out_red, out_green,
                    out_blue, output ready);
endinterface

@@ hw/rtl/glyph_alpha_blend_blit_core.sv @@
// Top level of the glyph alpha-blend blitter with clipping.
// Depends on gabb_pkg, gabb_ifs, gabb_cfg_regs, gabb_raster, gabb_blend.
`timescale 1ns / 1ps

//  channel   role     word contents
//  -------   ------   ----------------------------------------------------------
//  bitmap    sink     coverage, bg_red, bg_green, bg_blue, glyph_last
//  pixel     source   write_pixel, pos_x, pos_y, out_red, out_green, out_blue
//  cfg_*     write    cfg_we, cfg_index, cfg_data (no handshake, no read-back)
//
//  One bitmap word in, one pixel word out, one word per cycle sustained while
//  pixel.ready is high. The input register (with the raster counters) leads to
//  the result register; blend multiplies and clip compares sit between them.
//  A stall on pixel.ready holds the result register, then the input register,
//  then drops bitmap.ready; each stage refills in the cycle it empties.
//  Reset clears the counters and valid flags and presets the cfg registers.

module glyph_alpha_blend_blit_core #(
    parameter int MAX_GLYPH_WIDTH = gabb_pkg::GABB_MAX_GLYPH_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [gabb_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [gabb_pkg::CFG_DATA_W-1:0]   cfg_data,
    gabb_bitmap_if.sink                       bitmap,
    gabb_pixel_if.source                      pixel
);
    import gabb_pkg::*;

    cfg_t   cfg;
    stage_t stage;
    logic   stage_valid;
    logic   stage_ready;
    logic   take;

    logic                      visible;
    logic                      write_next;
    logic [7:0]                red_mix, green_mix, blue_mix;
    logic signed [COORD_W-1:0] clip_left_s, clip_top_s, clip_right_s, clip_bottom_s;

    logic                      result_valid_reg, result_valid_next;
    logic                      write_reg;
    logic signed [COORD_W-1:0] pos_x_reg, pos_y_reg;
    logic [7:0]                red_reg, green_reg, blue_reg;

    gabb_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    gabb_raster #(
        .MAX_GLYPH_WIDTH (MAX_GLYPH_WIDTH)
    ) u_raster (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .bitmap      (bitmap),
        .stage_ready (stage_ready),
        .stage_valid (stage_valid),
        .stage       (stage)
    );

    // clip bounds are unsigned; widen to the signed coordinate width
    assign clip_left_s   = $signed(COORD_W'(cfg.clip_left));
    assign clip_top_s    = $signed(COORD_W'(cfg.clip_top));
    assign clip_right_s  = $signed(COORD_W'(cfg.clip_right));
    assign clip_bottom_s = $signed(COORD_W'(cfg.clip_bottom));

    // an empty or inverted clip rectangle fails one of these by itself
    assign visible = (stage.pos_x >= clip_left_s) && (stage.pos_x < clip_right_s)
                  && (stage.pos_y >= clip_top_s)  && (stage.pos_y < clip_bottom_s);
    assign write_next = visible && (stage.coverage != 8'd0);

    gabb_blend u_blend_red (
        .fg      (cfg.fg_color[23:16]),
        .bg      (stage.bg_red),
        .alpha   (stage.coverage),
        .blended (red_mix)
    );

    gabb_blend u_blend_green (
        .fg      (cfg.fg_color[15:8]),
        .bg      (stage.bg_green),
        .alpha   (stage.coverage),
        .blended (green_mix)
    );

    gabb_blend u_blend_blue (
        .fg      (cfg.fg_color[7:0]),
        .bg      (stage.bg_blue),
        .alpha   (stage.coverage),
        .blended (blue_mix)
    );

    // result register frees up when empty or when its word is taken
    assign stage_ready = !result_valid_reg || pixel.ready;
    assign take        = stage_valid && stage_ready;

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (pixel.ready)
            result_valid_next = 1'b0;
        if (take)
            result_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= result_valid_next;
    end

    // payload: load on take, hold otherwise; unwritten pixels carry black
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            write_reg <= write_next;
            pos_x_reg <= stage.pos_x;
            pos_y_reg <= stage.pos_y;
            red_reg   <= write_next ? red_mix   : 8'd0;
            green_reg <= write_next ? green_mix : 8'd0;
            blue_reg  <= write_next ? blue_mix  : 8'd0;
        end
    end

    assign pixel.valid       = result_valid_reg;
    assign pixel.write_pixel = write_reg;
    assign pixel.pos_x       = pos_x_reg;
    assign pixel.pos_y       = pos_y_reg;
    assign pixel.out_red     = red_reg;
    assign pixel.out_green   = green_reg;
    assign pixel.out_blue    = blue_reg;

endmodule

@@ hw/rtl/gabb_cfg_regs.sv @@
// Configuration register file for the glyph blit core.
// Depends on gabb_pkg.
`timescale 1ns / 1ps

module gabb_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [gabb_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [gabb_pkg::CFG_DATA_W-1:0]   cfg_data,
    output gabb_pkg::cfg_t                    cfg
);
    import gabb_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ORIGIN_X:    cfg_next.origin_x    = $signed(cfg_data[12:0]);
                REG_ORIGIN_Y:    cfg_next.origin_y    = $signed(cfg_data[12:0]);
                REG_GLYPH_WIDTH: cfg_next.glyph_width = cfg_data[8:0];
                REG_FG_COLOR:    cfg_next.fg_color    = cfg_data[23:0];
                REG_CLIP_LEFT:   cfg_next.clip_left   = cfg_data[12:0];
                REG_CLIP_TOP:    cfg_next.clip_top    = cfg_data[12:0];
                REG_CLIP_RIGHT:  cfg_next.clip_right  = cfg_data[12:0];
                REG_CLIP_BOTTOM: cfg_next.clip_bottom = cfg_data[12:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x    <= '0;
            cfg_reg.origin_y    <= '0;
            cfg_reg.glyph_width <= 9'd1;
            cfg_reg.fg_color    <= '0;
            cfg_reg.clip_left   <= '0;
            cfg_reg.clip_top    <= '0;
            cfg_reg.clip_right  <= 13'd4096;
            cfg_reg.clip_bottom <= 13'd4096;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hw/rtl/gabb_raster.sv @@
// Input register and raster counters: tags each bitmap word with its screen position.
// Depends on gabb_pkg and gabb_ifs.
`timescale 1ns / 1ps

module gabb_raster #(
    parameter int MAX_GLYPH_WIDTH = gabb_pkg::GABB_MAX_GLYPH_WIDTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  gabb_pkg::cfg_t  cfg,
    gabb_bitmap_if.sink     bitmap,
    input  logic            stage_ready,
    output logic            stage_valid,
    output gabb_pkg::stage_t stage
);
    import gabb_pkg::*;

    localparam int CW     = (MAX_GLYPH_WIDTH > 1) ? $clog2(MAX_GLYPH_WIDTH) : 1;
    localparam int WW_MIN = $clog2(MAX_GLYPH_WIDTH + 1);
    localparam int WW     = (WW_MIN > 9) ? WW_MIN : 9;

    logic [CW-1:0]    column_reg, column_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             stage_valid_reg, stage_valid_next;
    stage_t           stage_reg, stage_next;
    logic             accept;
    logic [WW-1:0]    width_raw;
    logic [WW-1:0]    width_eff;
    logic [WW-1:0]    column_inc;

    assign bitmap.ready = !stage_valid_reg || stage_ready;
    assign accept       = bitmap.valid && bitmap.ready;

    // clamp the glyph width to 1..MAX_GLYPH_WIDTH
    assign width_raw  = WW'(cfg.glyph_width);
    assign column_inc = WW'(column_reg) + WW'(1);

    always_comb
    begin
        priority if (width_raw == '0)
            width_eff = WW'(1);
        else if (width_raw > WW'(MAX_GLYPH_WIDTH))
            width_eff = WW'(MAX_GLYPH_WIDTH);
        else
            width_eff = width_raw;
    end

    always_comb
    begin
        column_next = column_reg;
        row_next    = row_reg;
        if (accept)
        begin
            priority if (bitmap.glyph_last)
            begin
                column_next = '0;
                row_next    = '0;
            end
            else if (column_inc >= width_eff)
            begin
                column_next = '0;
                row_next    = row_reg + ROW_W'(1);
            end
            else
            begin
                column_next = column_inc[CW-1:0];
            end
        end
    end

    always_comb
    begin
        stage_next          = stage_reg;
        stage_valid_next    = stage_valid_reg;
        if (stage_ready)
            stage_valid_next = 1'b0;
        if (accept)
        begin
            stage_valid_next    = 1'b1;
            stage_next.coverage = bitmap.coverage;
            stage_next.bg_red   = bitmap.bg_red;
            stage_next.bg_green = bitmap.bg_green;
            stage_next.bg_blue  = bitmap.bg_blue;
            stage_next.pos_x    = COORD_W'(cfg.origin_x)
                                + $signed(COORD_W'(column_reg));
            stage_next.pos_y    = COORD_W'(cfg.origin_y)
                                + $signed(COORD_W'(row_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg      <= '0;
            row_reg         <= '0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            column_reg      <= column_next;
            row_reg         <= row_next;
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign stage_valid = stage_valid_reg;
    assign stage       = stage_reg;

endmodule

@@ hw/rtl/gabb_blend.sv @@
// One color channel of the rounded alpha blend, (fg*a + bg*(255-a) + 127) / 255.
// No dependencies.
`timescale 1ns / 1ps

module gabb_blend (
    input  logic [7:0] fg,
    input  logic [7:0] bg,
    input  logic [7:0] alpha,
    output logic [7:0] blended
);
    logic [7:0]  alpha_inv;
    logic [15:0] fg_term;
    logic [15:0] bg_term;
    logic [16:0] sum;
    logic [16:0] quot;

    assign alpha_inv = 8'hFF - alpha;
    assign fg_term   = 16'(fg) * 16'(alpha);
    assign bg_term   = 16'(bg) * 16'(alpha_inv);
    assign sum       = 17'(fg_term) + 17'(bg_term) + 17'd127;

    // divide by 255: exact for sums below 255*256
    assign quot    = sum + (sum >> 8) + 17'd1;
    assign blended = quot[15:8];

endmodule

@@ hw/rtl/gabb_checker.sv @@
// Port-level checker for the glyph blit core, bound to the top level.
// Depends on glyph_alpha_blend_blit_core_defines.svh and glyph_alpha_blend_blit_core.
`timescale 1ns / 1ps

`include "glyph_alpha_blend_blit_core_defines.svh"

module gabb_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic              write_pixel,
    input logic signed [13:0] pos_x,
    input logic signed [13:0] pos_y,
    input logic [7:0]        out_red,
    input logic [7:0]        out_green,
    input logic [7:0]        out_blue
);

    // a skipped pixel carries black
    `GABB_ASSERT_NOW(a_skip_black, out_valid && !write_pixel, (out_red == 8'd0) && (out_green == 8'd0) && (out_blue == 8'd0), "skipped pixel has nonzero color")

    // clip bounds are nonnegative, so a written pixel never lands left of or above zero
    `GABB_ASSERT_NOW(a_write_onscreen, out_valid && write_pixel, !pos_x[13] && !pos_y[13], "written pixel at negative position")

    // stalled word stays offered
    `GABB_ASSERT_NEXT(a_stall_valid, out_valid && !out_ready, out_valid, "pixel word dropped under stall")

    // stalled word holds its payload
    `GABB_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, $stable(pos_x) && $stable(pos_y) && $stable(write_pixel) && $stable(out_red) && $stable(out_green) && $stable(out_blue), "pixel word changed under stall")

endmodule

bind glyph_alpha_blend_blit_core gabb_checker u_gabb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (pixel.valid),
    .out_ready   (pixel.ready),
    .write_pixel (pixel.write_pixel),
    .pos_x       (pixel.pos_x),
    .pos_y       (pixel.pos_y),
    .out_red     (pixel.out_red),
    .out_green   (pixel.out_green),
    .out_blue    (pixel.out_blue)
);

@@ tb/glyph_alpha_blend_blit_core_test.sv @@
// Self-checking testbench for glyph_alpha_blend_blit_core: streams bitmap words
// through the core and checks every pixel word against an internal blend tracker.
// Depends on gabb_pkg, gabb_ifs and the core from the RTL; compile them first.
`timescale 1ns / 1ps

module glyph_alpha_blend_blit_core_test;

    import gabb_pkg::*;

    // Stop the run here if the core wedges; a clean run needs a small fraction.
    localparam int CYCLE_LIMIT   = 300000;
    // Random phases after the directed part; the last one streams one wide glyph.
    localparam int RANDOM_PHASES = 8;
    // Rows streamed at width 1 at the end, one word per row.
    localparam int WRAP_WORDS    = 40;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic [7:0] coverage;
        logic [7:0] bg_red;
        logic [7:0] bg_green;
        logic [7:0] bg_blue;
        logic       glyph_last;
    } bitmap_word_t;

    typedef struct packed {
        logic                      write_pixel;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic [7:0]                out_red;
        logic [7:0]                out_green;
        logic [7:0]                out_blue;
    } pixel_word_t;

    // Tracks the raster counters and the register copy, and holds the pixel
    // words the core still owes us, oldest first.
    class blend_tracker;
        cfg_t          regs;
        int            column_count;
        int            row_count;
        int            mismatches;
        pixel_word_t   pending_pixels[$];

        function new();
            regs.origin_x    = '0;
            regs.origin_y    = '0;
            regs.glyph_width = 9'd1;
            regs.fg_color    = '0;
            regs.clip_left   = '0;
            regs.clip_top    = '0;
            regs.clip_right  = 13'd4096;
            regs.clip_bottom = 13'd4096;
            column_count     = 0;
            row_count        = 0;
            mismatches       = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_ORIGIN_X:    regs.origin_x    = data[12:0];
                REG_ORIGIN_Y:    regs.origin_y    = data[12:0];
                REG_GLYPH_WIDTH: regs.glyph_width = data[8:0];
                REG_FG_COLOR:    regs.fg_color    = data[23:0];
                REG_CLIP_LEFT:   regs.clip_left   = data[12:0];
                REG_CLIP_TOP:    regs.clip_top    = data[12:0];
                REG_CLIP_RIGHT:  regs.clip_right  = data[12:0];
                REG_CLIP_BOTTOM: regs.clip_bottom = data[12:0];
                default: ;
            endcase
        endfunction

        function int mix(int fg, int bg, int alpha);
            return (fg * alpha + bg * (255 - alpha) + 127) / 255;
        endfunction

        // Work out the pixel word for an accepted bitmap word, then advance
        // the raster counters.
        function void take_word(bitmap_word_t w);
            int          eff_w;
            int          sx;
            int          sy;
            bit          inside_clip;
            pixel_word_t p;
            eff_w = regs.glyph_width;
            if (eff_w == 0)
                eff_w = 1;
            if (eff_w > GABB_MAX_GLYPH_WIDTH)
                eff_w = GABB_MAX_GLYPH_WIDTH;
            sx = int'($signed(regs.origin_x)) + column_count;
            sy = int'($signed(regs.origin_y)) + row_count;
            inside_clip = sx >= int'(regs.clip_left) && sx < int'(regs.clip_right) &&
                          sy >= int'(regs.clip_top) && sy < int'(regs.clip_bottom);
            p.write_pixel = inside_clip && w.coverage != 8'd0;
            p.pos_x       = COORD_W'(sx);
            p.pos_y       = COORD_W'(sy);
            p.out_red     = '0;
            p.out_green   = '0;
            p.out_blue    = '0;
            if (p.write_pixel) begin
                p.out_red   = 8'(mix(regs.fg_color[23:16], w.bg_red, w.coverage));
                p.out_green = 8'(mix(regs.fg_color[15:8], w.bg_green, w.coverage));
                p.out_blue  = 8'(mix(regs.fg_color[7:0], w.bg_blue, w.coverage));
            end
            pending_pixels.push_back(p);
            if (w.glyph_last) begin
                column_count = 0;
                row_count    = 0;
            end else if (column_count + 1 >= eff_w) begin
                column_count = 0;
                row_count    = (row_count + 1) % 4096;
            end else begin
                column_count = column_count + 1;
            end
        endfunction

        function void check_field(string fname, int want, int got_v);
            if (want != got_v) begin
                $display("%0t ERROR %s: expected %0d, got %0d", $time, fname, want, got_v);
                mismatches++;
            end
        endfunction

        function void match_pixel(pixel_word_t got);
            pixel_word_t want;
            if (pending_pixels.size() == 0) begin
                $display("%0t ERROR pixel word with none expected: expected nothing, got %h",
                         $time, got);
                mismatches++;
                return;
            end
            want = pending_pixels.pop_front();
            check_field("write_pixel", want.write_pixel, got.write_pixel);
            check_field("pos_x", $signed(want.pos_x), $signed(got.pos_x));
            check_field("pos_y", $signed(want.pos_y), $signed(got.pos_y));
            check_field("out_red", want.out_red, got.out_red);
            check_field("out_green", want.out_green, got.out_green);
            check_field("out_blue", want.out_blue, got.out_blue);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    gabb_bitmap_if bitmap_ch ();
    gabb_pixel_if  pixel_ch ();

    blend_tracker tracker = new();

    // Idle rates in percent, set per phase; hold_request asks the pixel side
    // for one long stretch with ready low.
    int bitmap_gap_pct  = 0;
    int pixel_stall_pct = 0;
    int hold_request    = 0;
    int cycle_count     = 0;

    glyph_alpha_blend_blit_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .bitmap    (bitmap_ch),
        .pixel     (pixel_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog: a wedged handshake must not hang the run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL glyph_alpha_blend_blit_core");
            $finish;
        end
    end

    // Pixel side: check the word taken at this edge, then pick ready for the
    // next one. Sampling right after the edge sees pre-edge values.
    initial
    begin
        int          hold_left;
        pixel_word_t got;
        hold_left = 0;
        pixel_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (pixel_ch.valid && pixel_ch.ready)
            begin
                got.write_pixel = pixel_ch.write_pixel;
                got.pos_x       = pixel_ch.pos_x;
                got.pos_y       = pixel_ch.pos_y;
                got.out_red     = pixel_ch.out_red;
                got.out_green   = pixel_ch.out_green;
                got.out_blue    = pixel_ch.out_blue;
                tracker.match_pixel(got);
            end
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                // hold off so the pipeline fills and backs up into bitmap.ready
                hold_left--;
                pixel_ch.ready <= 1'b0;
            end
            else
                pixel_ch.ready <= ($urandom_range(99) >= pixel_stall_pct);
        end
    end

    task automatic set_idle(idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin bitmap_gap_pct = 0;  pixel_stall_pct = 0;  end
            IDLE_SENDER:   begin bitmap_gap_pct = 53; pixel_stall_pct = 0;  end
            IDLE_RECEIVER: begin bitmap_gap_pct = 0;  pixel_stall_pct = 53; end
            IDLE_BOTH:     begin bitmap_gap_pct = 17; pixel_stall_pct = 17; end
            default: ;
        endcase
    endtask

    // Offer one bitmap word, with random gaps in front, and note it once the
    // core takes it. Valid stays high into the next word when no gap follows.
    task automatic send_word(logic [7:0] cov, logic [7:0] red, logic [7:0] green,
                             logic [7:0] blue, logic last);
        bitmap_word_t w;
        w = {cov, red, green, blue, last};
        while ($urandom_range(99) < bitmap_gap_pct)
        begin
            bitmap_ch.valid <= 1'b0;
            @(posedge clk);
        end
        bitmap_ch.valid      <= 1'b1;
        bitmap_ch.coverage   <= cov;
        bitmap_ch.bg_red     <= red;
        bitmap_ch.bg_green   <= green;
        bitmap_ch.bg_blue    <= blue;
        bitmap_ch.glyph_last <= last;
        @(posedge clk);
        while (!bitmap_ch.ready)
            @(posedge clk);
        tracker.take_word(w);
    endtask

    // Drop valid and wait until every owed pixel word is back, then let the
    // two-stage pipeline settle so the core is truly empty.
    task automatic wait_drain();
        bitmap_ch.valid <= 1'b0;
        while (tracker.pending_pixels.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        tracker.set_reg(index, data);
    endtask

    task automatic program_regs(cfg_t c);
        write_reg(REG_ORIGIN_X, {11'd0, c.origin_x});
        write_reg(REG_ORIGIN_Y, {11'd0, c.origin_y});
        write_reg(REG_GLYPH_WIDTH, {15'd0, c.glyph_width});
        write_reg(REG_FG_COLOR, c.fg_color);
        write_reg(REG_CLIP_LEFT, {11'd0, c.clip_left});
        write_reg(REG_CLIP_TOP, {11'd0, c.clip_top});
        write_reg(REG_CLIP_RIGHT, {11'd0, c.clip_right});
        write_reg(REG_CLIP_BOTTOM, {11'd0, c.clip_bottom});
        cfg_we <= 1'b0;
    endtask

    // Coverage weighted toward the blend corners: transparent, opaque, faint.
    function automatic logic [7:0] pick_coverage();
        case ($urandom_range(7))
            0, 1:    return 8'd0;
            2:       return 8'd255;
            3:       return 8'd1;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    initial
    begin
        cfg_t c;
        bitmap_ch.valid      <= 1'b0;
        bitmap_ch.coverage   <= '0;
        bitmap_ch.bg_red     <= '0;
        bitmap_ch.bg_green   <= '0;
        bitmap_ch.bg_blue    <= '0;
        bitmap_ch.glyph_last <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= '0;
        cfg_data             <= '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset registers first (width 1, black foreground, full clip).
        // Zero coverage leaves black, full coverage gives the foreground, a
        // faint one barely moves the background, and last clears the counters.
        set_idle(IDLE_NONE);
        send_word(8'd0, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_word(8'd255, 8'h00, 8'h80, 8'hFF, 1'b0);
        send_word(8'd1, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_word(8'd128, 8'h01, 8'h7F, 8'hFE, 1'b0);
        wait_drain();

        // Origins at their extremes: every pixel lands left of the clip.
        c = '{origin_x: -4096, origin_y: 4095, glyph_width: 3, fg_color: 24'hFFFFFF,
              clip_left: 0, clip_top: 0, clip_right: 4096, clip_bottom: 4096};
        program_regs(c);
        send_word(8'd255, 8'h00, 8'h00, 8'h00, 1'b0);
        send_word(8'd255, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_word(8'd200, 8'h55, 8'hAA, 8'h55, 1'b1);
        wait_drain();

        // Tight clip: columns 1..2 and rows 0..1 visible, so the left, right and bottom
        // edges are each hit from both sides across three rows of width four.
        c = '{origin_x: 0, origin_y: 0, glyph_width: 4, fg_color: 24'h00FF80,
              clip_left: 1, clip_top: 0, clip_right: 3, clip_bottom: 2};
        program_regs(c);
        for (int k = 0; k < 12; k++)
            send_word((k % 4 == 1) ? 8'd0 : 8'(255 - k), 8'(k * 21), 8'hFF, 8'h00, k == 11);
        send_word(8'd255, 8'h12, 8'h34, 8'h56, 1'b0);
        wait_drain();

        // Empty and inverted clip: nothing may be written.
        c = '{origin_x: 5, origin_y: 4, glyph_width: 2, fg_color: 24'hA5A5A5,
              clip_left: 5, clip_top: 9, clip_right: 5, clip_bottom: 3};
        program_regs(c);
        for (int k = 0; k < 3; k++)
            send_word(8'd255, 8'h80, 8'h80, 8'h80, k == 2);
        wait_drain();

        // Random phases: mostly whole glyphs with random content, some noise
        // with glyph_last dropped anywhere. Idle mode rotates per phase.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            int budget;
            int eff_w;
            int sent;
            int span;
            bit noise;
            bit wide;
            wide = (phase == RANDOM_PHASES - 1);

            c.origin_x = ($urandom_range(9) == 0) ? 13'($urandom_range(1) ? -4096 : 4095)
                                                  : 13'($urandom_range(120) - 40);
            c.origin_y = ($urandom_range(9) == 0) ? 13'($urandom_range(1) ? -4096 : 4095)
                                                  : 13'($urandom_range(60) - 20);
            case ($urandom_range(9))
                0:       c.glyph_width = 9'd0;
                1:       c.glyph_width = 9'd1;
                2:       c.glyph_width = 9'd256;
                3:       c.glyph_width = 9'($urandom_range(511, 257));
                default: c.glyph_width = 9'($urandom_range(12, 2));
            endcase
            // one wide glyph: width above the maximum clamps, column wraps at 256
            if (wide)
                c.glyph_width = $urandom_range(1) ? 9'd256 : 9'd511;
            c.fg_color  = 24'($urandom);
            c.clip_left = 13'($urandom_range(60));
            case ($urandom_range(9))
                0:       c.clip_right = 13'd4096;
                1:       c.clip_right = c.clip_left;
                2:       c.clip_right = 13'($urandom_range(c.clip_left));
                3:       c.clip_right = 13'h1FFF;
                default: c.clip_right = c.clip_left + 13'($urandom_range(80, 1));
            endcase
            c.clip_top = 13'($urandom_range(30));
            case ($urandom_range(9))
                0:       c.clip_bottom = 13'd4096;
                1:       c.clip_bottom = c.clip_top;
                2:       c.clip_bottom = 13'($urandom_range(c.clip_top));
                3:       c.clip_bottom = 13'h1FFF;
                default: c.clip_bottom = c.clip_top + 13'($urandom_range(40, 1));
            endcase
            program_regs(c);
            set_idle(idle_mode_t'(phase % 4));

            if (phase == 2)
            begin
                // long receiver hold-off while words keep coming: the core
                // fills up and must stall bitmap.ready; then pause until empty
                hold_request = 80;
                for (int k = 0; k < 24; k++)
                    send_word(pick_coverage(), 8'($urandom), 8'($urandom), 8'($urandom),
                              k == 23);
                wait_drain();
            end

            eff_w = (c.glyph_width == 0) ? 1 :
                    (c.glyph_width > GABB_MAX_GLYPH_WIDTH) ? GABB_MAX_GLYPH_WIDTH :
                    int'(c.glyph_width);
            budget = wide ? 300 : 24;
            sent   = 0;
            while (sent < budget)
            begin
                noise = !wide && ($urandom_range(6) == 0);
                span  = noise ? $urandom_range(20, 1) : eff_w * $urandom_range(4, 1);
                if (wide)
                    span = budget;
                else if (span > budget - sent)
                    span = budget - sent;
                for (int k = 0; k < span; k++)
                    send_word(pick_coverage(), 8'($urandom), 8'($urandom), 8'($urandom),
                              noise ? ($urandom_range(7) == 0) : (k == span - 1));
                sent += span;
            end
            wait_drain();
        end

        // Width 0 acts as 1, so each word starts a new row; the rows cross
        // the top clip edge going down, with no glyph_last until the very end.
        c = '{origin_x: 7, origin_y: -20, glyph_width: 0, fg_color: 24'($urandom),
              clip_left: 0, clip_top: 0, clip_right: 10, clip_bottom: 4096};
        program_regs(c);
        set_idle(IDLE_NONE);
        for (int k = 0; k < WRAP_WORDS; k++)
            send_word(pick_coverage(), 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
        send_word(8'd255, 8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
        send_word(8'd255, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
        wait_drain();

        repeat (8) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending_pixels.size() == 0)
            $display("PASS glyph_alpha_blend_blit_core");
        else
            $display("FAIL glyph_alpha_blend_blit_core");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/gabb_pkg.sv
hw/rtl/gabb_ifs.sv
hw/rtl/gabb_cfg_regs.sv
hw/rtl/gabb_raster.sv
hw/rtl/gabb_blend.sv
hw/rtl/glyph_alpha_blend_blit_core.sv
hw/rtl/gabb_checker.sv
tb/glyph_alpha_blend_blit_core_test.sv
